>>> hdl/drcu_pkg.sv
// Package for the debug run-control unit: sizes, command and stop codes,
// register addresses and the match struct. No dependencies.
`default_nettype none

package drcu_pkg;

    localparam int NUM_BREAKPOINTS  = 8;
    localparam int NUM_WATCHPOINTS  = 8;
    localparam int MAX_ACCESS_BYTES = 8;
    localparam int PHYS_ADDR_BITS   = 29;
    localparam int SIZE_W           = $clog2(MAX_ACCESS_BYTES + 1);

    localparam logic [3:0] CMD_EXEC      = 4'd0;
    localparam logic [3:0] CMD_BUS_RD    = 4'd1;
    localparam logic [3:0] CMD_BUS_WR    = 4'd2;
    localparam logic [3:0] CMD_PAUSE     = 4'd3;
    localparam logic [3:0] CMD_RESUME    = 4'd4;
    localparam logic [3:0] CMD_STEP      = 4'd5;
    localparam logic [3:0] CMD_SET_BP    = 4'd6;
    localparam logic [3:0] CMD_SET_WP    = 4'd7;
    localparam logic [3:0] CMD_RESET     = 4'd8;

    localparam logic [2:0] STOP_RUNNING  = 3'd0;
    localparam logic [2:0] STOP_USER     = 3'd1;
    localparam logic [2:0] STOP_BREAK    = 3'd2;
    localparam logic [2:0] STOP_WATCH    = 3'd3;
    localparam logic [2:0] STOP_STEP     = 3'd4;
    localparam logic [2:0] STOP_EXCEPT   = 3'd5;

    localparam int         CFG_ADDR_W        = 3;
    localparam logic [2:0] ADDR_DEBUG_ENABLE = 3'd0;

    typedef struct packed {
        logic bp_hit;
        logic wp_hit;
    } t_match;

endpackage

`default_nettype wire

>>> hdl/drcu_tables.sv
// Breakpoint and watchpoint tables with their parallel comparators.
// Depends on drcu_pkg.
`default_nettype none

module drcu_tables (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [3:0]           i_cmd,
    input  wire logic [63:0]          i_address,
    input  wire logic [3:0]           i_access_size,
    input  wire logic [2:0]           i_slot_index,
    input  wire logic                 i_slot_valid,
    input  wire logic                 i_watch_on_read,
    input  wire logic                 i_watch_on_write,
    output drcu_pkg::t_match          o_match
);

    localparam int NBP = drcu_pkg::NUM_BREAKPOINTS;
    localparam int NWP = drcu_pkg::NUM_WATCHPOINTS;
    localparam int PA  = drcu_pkg::PHYS_ADDR_BITS;
    localparam int SW  = drcu_pkg::SIZE_W;

    logic [NBP-1:0] r_bp_vld;
    logic [63:0]    r_bp_pc [NBP];
    logic [NWP-1:0] r_wp_vld;
    logic [PA-1:0]  r_wp_addr [NWP];
    logic [NWP-1:0] r_wp_rd;
    logic [NWP-1:0] r_wp_wr;

    logic           wr_bp;
    logic           wr_wp;
    logic [PA-1:0]  base;
    logic [SW-1:0]  eff_size;
    logic           bus_wr;

    assign wr_bp  = i_wr_en && (i_cmd == drcu_pkg::CMD_SET_BP);
    assign wr_wp  = i_wr_en && (i_cmd == drcu_pkg::CMD_SET_WP);
    assign base   = i_address[PA-1:0];
    assign bus_wr = (i_cmd == drcu_pkg::CMD_BUS_WR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_vld <= '0;
            r_wp_vld <= '0;
        end else begin
            for (int i = 0; i < NBP; i++) begin
                if (wr_bp && int'(i_slot_index) == i) begin
                    r_bp_vld[i] <= i_slot_valid;
                end
            end
            for (int i = 0; i < NWP; i++) begin
                if (wr_wp && int'(i_slot_index) == i) begin
                    r_wp_vld[i] <= i_slot_valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NBP; i++) begin
            if (wr_bp && int'(i_slot_index) == i) begin
                r_bp_pc[i] <= i_address;
            end
        end
        for (int i = 0; i < NWP; i++) begin
            if (wr_wp && int'(i_slot_index) == i) begin
                r_wp_addr[i] <= base;
                r_wp_rd[i]   <= i_watch_on_read;
                r_wp_wr[i]   <= i_watch_on_write || !i_watch_on_read;
            end
        end
    end

    always_comb begin
        if (i_access_size == 4'd0) begin
            eff_size = SW'(1);
        end else if (int'(i_access_size) > drcu_pkg::MAX_ACCESS_BYTES) begin
            eff_size = SW'(drcu_pkg::MAX_ACCESS_BYTES);
        end else begin
            eff_size = SW'(i_access_size);
        end
    end

    always_comb begin
        logic          dir;
        logic [PA-1:0] diff;
        o_match = '0;
        for (int i = 0; i < NBP; i++) begin
            if (r_bp_vld[i] && r_bp_pc[i] == i_address) begin
                o_match.bp_hit = 1'b1;
            end
        end
        for (int i = 0; i < NWP; i++) begin
            dir  = bus_wr ? r_wp_wr[i] : r_wp_rd[i];
            diff = r_wp_addr[i] - base;
            if (r_wp_vld[i] && dir && diff < PA'(eff_size)) begin
                o_match.wp_hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/debug_run_control_unit.sv
// Debug run-control unit: input register, run-state update and result register.
// Requests pass from the input register to the result register, one request per cycle
// while the result is not stalled. A stalled result holds the input register.
// Synchronous active-low reset clears run state, counters and table valid bits;
// table contents are not cleared and no clearing pass is needed.
// Depends on drcu_pkg and drcu_tables.
`default_nettype none

module debug_run_control_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [drcu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [3:0]                      i_cmd,
    input  wire logic [63:0]                     i_address,
    input  wire logic [3:0]                      i_access_size,
    input  wire logic [31:0]                     i_step_count,
    input  wire logic                            i_pause_cause,
    input  wire logic [2:0]                      i_slot_index,
    input  wire logic                            i_slot_valid,
    input  wire logic                            i_watch_on_read,
    input  wire logic                            i_watch_on_write,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_proceed,
    output logic                                 o_is_paused,
    output logic [2:0]                           o_stop_code,
    output logic [31:0]                          o_breakpoint_hits,
    output logic [31:0]                          o_watchpoint_hits
);

    logic        r_dbg_en;
    logic        r_in_vld;
    logic [3:0]  r_in_cmd;
    logic [63:0] r_in_address;
    logic [3:0]  r_in_access_size;
    logic [31:0] r_in_step_count;
    logic        r_in_pause_cause;
    logic [2:0]  r_in_slot_index;
    logic        r_in_slot_valid;
    logic        r_in_watch_on_read;
    logic        r_in_watch_on_write;

    logic        r_out_vld;
    logic        r_proceed;
    logic        r_paused;
    logic [2:0]  r_stop;
    logic [31:0] r_steps;
    logic        r_skip_vld;
    logic [63:0] r_skip_pc;
    logic [31:0] r_bp_cnt;
    logic [31:0] r_wp_cnt;

    logic        n_proceed;
    logic        n_paused;
    logic [2:0]  n_stop;
    logic [31:0] n_steps;
    logic        n_skip_vld;
    logic [63:0] n_skip_pc;
    logic [31:0] n_bp_cnt;
    logic [31:0] n_wp_cnt;

    logic             adv;
    logic             cfg_wr;
    drcu_pkg::t_match match;

    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign cfg_wr     = psel && penable && pwrite && (paddr == drcu_pkg::ADDR_DEBUG_ENABLE);
    assign pready     = 1'b1;
    assign prdata     = (paddr == drcu_pkg::ADDR_DEBUG_ENABLE) ? {31'd0, r_dbg_en} : 32'd0;

    drcu_tables u_tables (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr_en          (adv),
        .i_cmd            (r_in_cmd),
        .i_address        (r_in_address),
        .i_access_size    (r_in_access_size),
        .i_slot_index     (r_in_slot_index),
        .i_slot_valid     (r_in_slot_valid),
        .i_watch_on_read  (r_in_watch_on_read),
        .i_watch_on_write (r_in_watch_on_write),
        .o_match          (match)
    );

    always_comb begin
        n_proceed  = 1'b1;
        n_paused   = r_paused;
        n_stop     = r_stop;
        n_steps    = r_steps;
        n_skip_vld = r_skip_vld;
        n_skip_pc  = r_skip_pc;
        n_bp_cnt   = r_bp_cnt;
        n_wp_cnt   = r_wp_cnt;
        unique case (r_in_cmd) inside
            drcu_pkg::CMD_EXEC: begin
                if (r_dbg_en) begin
                    if (r_paused && r_steps == 32'd0) begin
                        n_proceed = 1'b0;
                    end else if (r_skip_vld && r_skip_pc == r_in_address) begin
                        n_skip_vld = 1'b0;
                    end else begin
                        n_skip_vld = 1'b0;
                        if (match.bp_hit) begin
                            n_proceed  = 1'b0;
                            n_bp_cnt   = r_bp_cnt + 32'd1;
                            n_skip_vld = 1'b1;
                            n_skip_pc  = r_in_address;
                            n_paused   = 1'b1;
                            n_stop     = drcu_pkg::STOP_BREAK;
                            n_steps    = 32'd0;
                        end
                    end
                    if (n_proceed && r_steps != 32'd0) begin
                        n_steps = r_steps - 32'd1;
                        if (r_steps == 32'd1) begin
                            n_paused = 1'b1;
                            n_stop   = drcu_pkg::STOP_STEP;
                        end
                    end
                end
            end
            drcu_pkg::CMD_BUS_RD, drcu_pkg::CMD_BUS_WR: begin
                if (r_dbg_en && match.wp_hit) begin
                    n_wp_cnt = r_wp_cnt + 32'd1;
                    n_paused = 1'b1;
                    n_stop   = drcu_pkg::STOP_WATCH;
                    n_steps  = 32'd0;
                end
            end
            drcu_pkg::CMD_PAUSE: begin
                n_paused = 1'b1;
                n_stop   = r_in_pause_cause ? drcu_pkg::STOP_EXCEPT : drcu_pkg::STOP_USER;
                n_steps  = 32'd0;
            end
            drcu_pkg::CMD_RESUME: begin
                n_paused = 1'b0;
                n_stop   = drcu_pkg::STOP_RUNNING;
                n_steps  = 32'd0;
            end
            drcu_pkg::CMD_STEP: begin
                n_steps  = (r_in_step_count == 32'd0) ? 32'd1 : r_in_step_count;
                n_paused = 1'b0;
                n_stop   = drcu_pkg::STOP_RUNNING;
            end
            drcu_pkg::CMD_RESET: begin
                n_paused   = 1'b0;
                n_stop     = drcu_pkg::STOP_RUNNING;
                n_steps    = 32'd0;
                n_skip_vld = 1'b0;
                n_skip_pc  = 64'd0;
                n_bp_cnt   = 32'd0;
                n_wp_cnt   = 32'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbg_en   <= 1'b0;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_proceed  <= 1'b1;
            r_paused   <= 1'b0;
            r_stop     <= drcu_pkg::STOP_RUNNING;
            r_steps    <= 32'd0;
            r_skip_vld <= 1'b0;
            r_skip_pc  <= 64'd0;
            r_bp_cnt   <= 32'd0;
            r_wp_cnt   <= 32'd0;
        end else begin
            if (cfg_wr) begin
                r_dbg_en <= pwdata[0];
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld  <= 1'b1;
                r_proceed  <= n_proceed;
                r_paused   <= n_paused;
                r_stop     <= n_stop;
                r_steps    <= n_steps;
                r_skip_vld <= n_skip_vld;
                r_skip_pc  <= n_skip_pc;
                r_bp_cnt   <= n_bp_cnt;
                r_wp_cnt   <= n_wp_cnt;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd            <= i_cmd;
            r_in_address        <= i_address;
            r_in_access_size    <= i_access_size;
            r_in_step_count     <= i_step_count;
            r_in_pause_cause    <= i_pause_cause;
            r_in_slot_index     <= i_slot_index;
            r_in_slot_valid     <= i_slot_valid;
            r_in_watch_on_read  <= i_watch_on_read;
            r_in_watch_on_write <= i_watch_on_write;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_proceed         = r_proceed;
    assign o_is_paused       = r_paused;
    assign o_stop_code       = r_stop;
    assign o_breakpoint_hits = r_bp_cnt;
    assign o_watchpoint_hits = r_wp_cnt;

endmodule

`default_nettype wire
